@@ sv/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

   // field widths of the stream words
   localparam int CMD_W       = 1;
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = 11;
   localparam int CUR_W       = 11;
   localparam int DATA_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   // commands
   localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // control characters
   localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h00;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_ATTR  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLANK_ATTR = 1'b1;

   localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET  = 8'd7;
   localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd0;

   // cursor update requested by the sequencer
   typedef enum logic [1:0] {
      CUR_HOLD,
      CUR_STEP,
      CUR_NEWLINE,
      CUR_HOME_LAST
   } cur_op_type;

endpackage

`default_nettype wire

@@ sv/text_console_writer.sv @@
`default_nettype none

// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tuser: cmd; tdata: char_code, cell_index
// rsp      out        rsp_tvalid/tready    tdata: cursor_pos, scrolled, read_data
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata (always ready)
//
// One word at a time goes through the sequencer. A printed character or a
// newline goes straight to the result step, a read first waits for the
// registered RAM read, and a tab steps the cursor TAB_ADVANCE columns, one
// column a cycle. A scroll copies the single-port-write cell RAM up one row,
// one cell a cycle, then fills the last row. After reset a clearing pass
// writes every cell while req_tready stays low. The result sits in an output
// register; while a stalled rsp side holds it, the next word is still taken
// and parks at the result step until that register is free or drains.

module text_console_writer #(
   parameter int WIDTH       = 80,
   parameter int HEIGHT      = 25,
   parameter int TAB_ADVANCE = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request: tuser = cmd
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [tcw_pkg::CMD_W-1:0]            req_tuser,
   // request: tdata = char_code[7:0], cell_index[18:8], zero pad
   input  wire  [tcw_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // response: tdata = cursor_pos[10:0], scrolled[11], read_data[27:12], zero pad
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // register writes
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [tcw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [tcw_pkg::ATTR_W-1:0]           csr_wdata
);
   import tcw_pkg::*;

   localparam int NCELLS     = WIDTH * HEIGHT;
   localparam int ADDR_W     = $clog2(NCELLS);
   localparam int POS_W      = $clog2(NCELLS + WIDTH + TAB_ADVANCE);
   localparam int TAB_CNT_W  = $clog2(TAB_ADVANCE + 1);
   localparam int CMP_W      = IDX_W + ADDR_W;
   localparam int EXT_W      = POS_W + CUR_W;
   localparam int PAD_W      = RSP_TDATA_W - CUR_W - 1 - DATA_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NCELLS - 1);
   localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(WIDTH * (HEIGHT - 1));
   localparam logic [CUR_W-1:0]  LAST_ROW_CUR = CUR_W'(WIDTH * (HEIGHT - 1));

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RDWAIT,
      ST_TAB,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_RESULT
   } state_type;

   state_type               state_ff;
   logic [ADDR_W-1:0]       cnt_ff;
   logic [TAB_CNT_W-1:0]    tab_cnt_ff;
   logic                    cp_pend_ff;
   logic [ADDR_W-1:0]       cp_dst_ff;
   logic                    rd_oor_ff;
   logic                    scr_ff;
   logic [DATA_W-1:0]       rdata_ff;
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff;
   logic [ATTR_W-1:0]       text_attr_ff;
   logic [ATTR_W-1:0]       blank_attr_ff;

   // cell RAM
   logic [DATA_W-1:0]       screen_mem [NCELLS];
   logic [DATA_W-1:0]       rd_data_ff;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [DATA_W-1:0]       mem_wdata;
   logic [ADDR_W-1:0]       mem_raddr;

   // request fields
   logic [CMD_W-1:0]        req_cmd;
   logic [CHAR_W-1:0]       req_char_code;
   logic [IDX_W-1:0]        req_cell_index;
   logic [CMP_W-1:0]        idx_ext;
   logic                    idx_oor;
   logic                    req_acc;
   logic                    put_print;

   cur_op_type              cur_op;
   logic [POS_W-1:0]        cur_pos;
   logic                    past_end;
   logic [EXT_W-1:0]        pos_ext;
   logic                    out_load;

   assign req_cmd        = req_tuser;
   assign req_char_code  = req_tdata[CHAR_W-1:0];
   assign req_cell_index = req_tdata[CHAR_W +: IDX_W];
   assign idx_ext        = CMP_W'(req_cell_index);
   assign idx_oor        = (idx_ext >= CMP_W'(NCELLS));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign put_print  = (req_cmd == CMD_PUT) && (req_char_code != CODE_TAB)
                       && (req_char_code != CODE_NEWLINE);

   assign out_load = (state_ff == ST_RESULT) && !past_end
                     && (!rsp_valid_ff || rsp_tready);
   assign pos_ext  = EXT_W'(cur_pos);

   tcw_cursor #(
      .WIDTH       (WIDTH),
      .HEIGHT      (HEIGHT),
      .TAB_ADVANCE (TAB_ADVANCE)
   ) u_cursor (
      .clock    (clock),
      .reset    (reset),
      .op       (cur_op),
      .pos      (cur_pos),
      .past_end (past_end)
   );

   // cursor moves: print and newline at accept, tab one step a cycle,
   // scroll homes it to the last row before the copy starts
   always_comb begin
      cur_op = CUR_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_cmd == CMD_PUT)) begin
               if (req_char_code == CODE_NEWLINE) begin
                  cur_op = CUR_NEWLINE;
               end else if (req_char_code != CODE_TAB) begin
                  cur_op = CUR_STEP;
               end
            end
         end
         ST_TAB:    cur_op = CUR_STEP;
         ST_RESULT: begin
            if (past_end) begin
               cur_op = CUR_HOME_LAST;
            end
         end
         default:   cur_op = CUR_HOLD;
      endcase
   end

   // single write port and single read port of the cell RAM
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = {TEXT_ATTR_RESET, CHAR_BLANK};
      mem_raddr = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            // cursor is always on screen here, so its low bits are the address
            mem_we    = req_acc && put_print;
            mem_waddr = cur_pos[ADDR_W-1:0];
            mem_wdata = {text_attr_ff, req_char_code};
            mem_raddr = idx_ext[ADDR_W-1:0];
         end
         ST_COPY, ST_DRAIN: begin
            mem_we    = cp_pend_ff;
            mem_waddr = cp_dst_ff;
            mem_wdata = rd_data_ff;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = {blank_attr_ff, CHAR_BLANK};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

   // register writes, taken in any state
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= TEXT_ATTR_RESET;
         blank_attr_ff <= BLANK_ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TEXT_ATTR:  text_attr_ff  <= csr_wdata;
            REG_BLANK_ATTR: blank_attr_ff <= csr_wdata;
            default: begin
               text_attr_ff <= text_attr_ff;
            end
         endcase
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         tab_cnt_ff   <= '0;
         cp_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scr_ff       <= 1'b0;
      end else begin
         // load a fresh result, or drop the one just taken
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_acc) begin
                  scr_ff    <= 1'b0;
                  rdata_ff  <= '0;
                  rd_oor_ff <= idx_oor;
                  if (req_cmd == CMD_READ) begin
                     state_ff <= ST_RDWAIT;
                  end else if (req_char_code == CODE_TAB) begin
                     tab_cnt_ff <= TAB_CNT_W'(TAB_ADVANCE);
                     state_ff   <= ST_TAB;
                  end else begin
                     state_ff <= ST_RESULT;
                  end
               end
            end
            ST_RDWAIT: begin
               rdata_ff <= rd_oor_ff ? '0 : rd_data_ff;
               state_ff <= ST_RESULT;
            end
            ST_TAB: begin
               tab_cnt_ff <= tab_cnt_ff - TAB_CNT_W'(1);
               if (tab_cnt_ff == TAB_CNT_W'(1)) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_COPY: begin
               // read row below, write it one row up on the next cycle
               cp_pend_ff <= 1'b1;
               cp_dst_ff  <= cnt_ff - ADDR_W'(WIDTH);
               cnt_ff     <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == LAST_ADDR) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               cp_pend_ff <= 1'b0;
               cnt_ff     <= FILL_START;
               state_ff   <= ST_FILL;
            end
            ST_FILL: begin
               cnt_ff <= cnt_ff + ADDR_W'(1);
               if (cnt_ff == LAST_ADDR) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (past_end) begin
                  scr_ff     <= 1'b1;
                  cnt_ff     <= ADDR_W'(WIDTH);
                  cp_pend_ff <= 1'b0;
                  state_ff   <= ST_COPY;
               end else if (out_load) begin
                  rsp_tdata_ff <= {{PAD_W{1'b0}}, rdata_ff, scr_ff, pos_ext[CUR_W-1:0]};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // the cursor is back on screen whenever a new word may be taken
   a_idle_on_screen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !past_end)
      else $error("cursor past end of screen while idle");

   // no RAM write ever lands beyond the last cell
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr <= LAST_ADDR))
      else $error("cell write address out of range");

   // a result is loaded only into a free or draining output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before taken");

   // a scrolled result reports the cursor at the start of the last row
   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      (out_load && scr_ff) |=> (rsp_tdata[CUR_W-1:0] == LAST_ROW_CUR))
      else $error("scroll left cursor off the last row");

endmodule

`default_nettype wire

@@ sv/tcw_cursor.sv @@
`default_nettype none

module tcw_cursor #(
   parameter int WIDTH       = 80,
   parameter int HEIGHT      = 25,
   parameter int TAB_ADVANCE = 8,
   localparam int NCELLS     = WIDTH * HEIGHT,
   localparam int POS_W      = $clog2(NCELLS + WIDTH + TAB_ADVANCE)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  tcw_pkg::cur_op_type   op,
   output logic [POS_W-1:0]      pos,
   output logic                  past_end
);
   import tcw_pkg::*;

   localparam int COL_W = $clog2(WIDTH);

   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   always_comb begin
      col_in = col_ff;
      pos_in = pos_ff;
      case (op)
         CUR_STEP: begin
            // one column forward; linear position always grows by one
            if (col_ff == COL_W'(WIDTH - 1)) begin
               col_in = '0;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            pos_in = pos_ff + POS_W'(1);
         end
         CUR_NEWLINE: begin
            col_in = '0;
            pos_in = pos_ff - POS_W'(col_ff) + POS_W'(WIDTH);
         end
         CUR_HOME_LAST: begin
            col_in = '0;
            pos_in = POS_W'(WIDTH * (HEIGHT - 1));
         end
         default: begin
            col_in = col_ff;
            pos_in = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         pos_ff <= '0;
      end else begin
         col_ff <= col_in;
         pos_ff <= pos_in;
      end
   end

   assign pos      = pos_ff;
   assign past_end = (pos_ff >= POS_W'(NCELLS));

endmodule

`default_nettype wire
